FILE: hdl/ptl_pkg.sv
// ----------------------------------------------------------------------------
// Peer table package
// Shared types and codes for the peer table with liveness aging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptl_pkg;

  localparam int MAC_W   = 48;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  // action codes on the input item
  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_ACTIVITY = 2'd1;
  localparam logic [1:0] ACT_SWEEP    = 2'd2;
  localparam logic [1:0] ACT_CLEAR    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_NEW   = 3'd0;
  localparam logic [2:0] ST_KNOWN = 3'd1;
  localparam logic [2:0] ST_BCAST = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEV = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             new_peer;
    logic [CNT_W-1:0] online_count;
    logic [CNT_W-1:0] seen_count;
    logic [CNT_W-1:0] device_count;
    logic             ready_res;
    logic             any_online;
  } out_item_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_REGISTER,
    OP_ACTIVITY,
    OP_SWEEP,
    OP_CLEAR,
    OP_BCAST
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now_ms;
  } job_t;

endpackage

FILE: hdl/ptl_front.sv
// ----------------------------------------------------------------------------
// Peer table front end
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptl_front
  import ptl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t cmd,
  output logic     busy,
  input  logic     pop,
  output logic     q_valid,
  output job_t     q_job
);

  localparam int QDEPTH = 2;

  job_t        q_mem [QDEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  q_cnt;
  logic        push;
  job_t        job_in;

  // classify: broadcast address short-circuits register and activity
  always_comb begin
    job_in.mac    = cmd.mac;
    job_in.now_ms = cmd.now_ms;
    unique case (cmd.action)
      ACT_REGISTER: job_in.op = (cmd.mac == BCAST_MAC) ? OP_BCAST : OP_REGISTER;
      ACT_ACTIVITY: job_in.op = (cmd.mac == BCAST_MAC) ? OP_BCAST : OP_ACTIVITY;
      ACT_SWEEP:    job_in.op = OP_SWEEP;
      ACT_CLEAR:    job_in.op = OP_CLEAR;
      default:      job_in.op = OP_CLEAR;
    endcase
  end

  assign busy    = (q_cnt == 2'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (q_cnt != 2'd0);
  assign q_job   = q_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= job_in;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        q_cnt <= q_cnt + 2'd1;
      end else if (pop && !push) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/ptl_back.sv
// ----------------------------------------------------------------------------
// Peer table back end
// Walks the table one entry a cycle for lookup and aging, inserts,
// clears and produces one result per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptl_back
  import ptl_pkg::*;
#(
  parameter int MAX_PEERS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              pop,
  input  logic [TIME_W-1:0] timeout_ms,
  input  logic [CNT_W-1:0]  min_devices,
  output logic              done,
  output out_item_t         result
);

  localparam int CNTW = $clog2(MAX_PEERS + 1);
  localparam int IDXW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int DEVW = CNTW + 1;
  localparam int CMPW = (DEVW > CNT_W) ? DEVW : CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_DONE
  } state_t;

  state_t            state;
  job_t              job;
  logic [CNTW-1:0]   total;
  logic [CNTW-1:0]   online_cnt;
  logic [CNTW-1:0]   seen_cnt;
  logic [MAX_PEERS-1:0] online_bits;
  logic [MAX_PEERS-1:0] seen_bits;
  logic [CNTW-1:0]   issue_idx;
  logic [IDXW-1:0]   cmp_idx;
  logic              cmp_vld;
  logic [2:0]        status_r;
  logic              new_r;

  logic [MAC_W-1:0]  addr_mem [MAX_PEERS];
  logic [TIME_W-1:0] time_mem [MAX_PEERS];
  logic [MAC_W-1:0]  rd_mac;
  logic [TIME_W-1:0] rd_time;

  logic              issuing;
  logic              match;
  logic              expire;
  logic              now_nz;
  logic              has_room;
  logic [IDXW-1:0]   ins_idx;
  logic              addr_we;
  logic              refresh_we;
  logic              time_we;
  logic [IDXW-1:0]   time_idx;
  logic [DEVW-1:0]   dev;

  assign pop      = (state == S_IDLE) && q_valid;
  assign issuing  = (state == S_SCAN) && (issue_idx < total);
  assign now_nz   = (job.now_ms != '0);
  assign has_room = (total < CNTW'(MAX_PEERS));
  assign ins_idx  = total[IDXW-1:0];
  assign match    = cmp_vld && (rd_mac == job.mac);
  // wrapping age compared against the timeout
  assign expire   = cmp_vld && online_bits[cmp_idx] && seen_bits[cmp_idx] &&
                    (TIME_W'(job.now_ms - rd_time) > timeout_ms);
  assign dev      = DEVW'(total) + DEVW'(1);

  // memory write controls
  assign addr_we    = (state == S_INSERT) && has_room;
  assign refresh_we = (state == S_SCAN) && (job.op == OP_ACTIVITY) && match;
  assign time_we    = addr_we || refresh_we;
  assign time_idx   = addr_we ? ins_idx : cmp_idx;

  // address and last-seen stores
  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[ins_idx] <= job.mac;
    end
    if (time_we) begin
      time_mem[time_idx] <= job.now_ms;
    end
    if (issuing) begin
      rd_mac  <= addr_mem[issue_idx[IDXW-1:0]];
      rd_time <= time_mem[issue_idx[IDXW-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      total       <= '0;
      online_cnt  <= '0;
      seen_cnt    <= '0;
      online_bits <= '0;
      seen_bits   <= '0;
      issue_idx   <= '0;
      cmp_vld     <= 1'b0;
      done        <= 1'b0;
    end else begin
      // strobe for exactly the cycle after the publish state
      done <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            job       <= q_job;
            new_r     <= 1'b0;
            issue_idx <= '0;
            cmp_vld   <= 1'b0;
            unique case (q_job.op)
              OP_BCAST: begin
                status_r <= ST_BCAST;
                state    <= S_DONE;
              end
              OP_CLEAR: begin
                total       <= '0;
                online_cnt  <= '0;
                seen_cnt    <= '0;
                online_bits <= '0;
                seen_bits   <= '0;
                status_r    <= ST_DONE;
                state       <= S_DONE;
              end
              OP_SWEEP: begin
                status_r <= ST_DONE;
                state    <= (total == '0) ? S_DONE : S_SCAN;
              end
              OP_REGISTER, OP_ACTIVITY: begin
                state <= (total == '0) ? S_INSERT : S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_SCAN: begin
          // one read issued and one entry compared per cycle
          cmp_vld <= issuing;
          cmp_idx <= issue_idx[IDXW-1:0];
          if (issuing) begin
            issue_idx <= issue_idx + CNTW'(1);
          end
          if (job.op == OP_SWEEP) begin
            if (expire) begin
              online_bits[cmp_idx] <= 1'b0;
              online_cnt           <= online_cnt - CNTW'(1);
            end
            if (!issuing) begin
              state <= S_DONE;
            end
          end else begin
            if (match) begin
              status_r <= ST_KNOWN;
              state    <= S_DONE;
              if (job.op == OP_ACTIVITY) begin
                online_bits[cmp_idx] <= 1'b1;
                seen_bits[cmp_idx]   <= now_nz;
                if (!online_bits[cmp_idx]) begin
                  online_cnt <= online_cnt + CNTW'(1);
                end
                if (now_nz && !seen_bits[cmp_idx]) begin
                  seen_cnt <= seen_cnt + CNTW'(1);
                end else if (!now_nz && seen_bits[cmp_idx]) begin
                  seen_cnt <= seen_cnt - CNTW'(1);
                end
              end
            end else if (!issuing) begin
              state <= S_INSERT;
            end
          end
        end

        S_INSERT: begin
          if (has_room) begin
            online_bits[ins_idx] <= 1'b1;
            seen_bits[ins_idx]   <= now_nz;
            online_cnt           <= online_cnt + CNTW'(1);
            if (now_nz) begin
              seen_cnt <= seen_cnt + CNTW'(1);
            end
            total    <= total + CNTW'(1);
            new_r    <= 1'b1;
            status_r <= ST_NEW;
          end else begin
            status_r <= ST_FULL;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // counts are settled here; publish the result
          result.status       <= status_r;
          result.new_peer     <= new_r;
          result.online_count <= CNT_W'(online_cnt);
          result.seen_count   <= CNT_W'(seen_cnt);
          result.device_count <= CNT_W'(dev);
          result.ready_res    <= (CMPW'(dev) >= CMPW'(min_devices));
          result.any_online   <= (online_cnt != '0);
          state               <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/peer_table_with_liveness_aging.sv
// ----------------------------------------------------------------------------
// Peer table with liveness aging
// Table of peer MAC addresses with last-seen time and online flag.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the command transfers on a
//   rising edge with start high and busy low. busy rises only while the
//   two-entry command queue is full.
//   Result channel: one result per command, on result for a single cycle
//   with done high. Results come in command order and cannot be held off.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 timeout_ms, 1 min_devices) at once; write only while idle.
// Sequence, block idle: broadcast, clear and empty-table sweep go straight
//   to the publish state; an empty-table insert passes the insert state.
//   Lookup and sweep walk the stored entries one per cycle through the
//   registered read port of the address and time stores: a sweep visits all
//   N stored peers (at most MAX_PEERS), a miss visits all N and then inserts,
//   and a hit stops at entry k (counted from zero). One command is worked on
//   at a time; the queue absorbs up to two more.
// Reset: synchronous; empties the table, clears the queue, restores
//   timeout_ms to 5000 and min_devices to 2. No result is pending after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_table_with_liveness_aging
  import ptl_pkg::*;
#(
  parameter int MAX_PEERS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  output logic                 done,
  output out_item_t            result
);

  logic [TIME_W-1:0] timeout_ms;
  logic [CNT_W-1:0]  min_devices;
  logic              q_valid;
  job_t              q_job;
  logic              pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms  <= TIME_W'(5000);
      min_devices <= CNT_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT: timeout_ms  <= cfg_data;
        REG_MIN_DEV: min_devices <= cfg_data[CNT_W-1:0];
        default:     timeout_ms  <= timeout_ms;
      endcase
    end
  end

  ptl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .pop     (pop),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  ptl_back #(
    .MAX_PEERS (MAX_PEERS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .pop         (pop),
    .timeout_ms  (timeout_ms),
    .min_devices (min_devices),
    .done        (done),
    .result      (result)
  );

endmodule

FILE: hdl/ptl_checker.sv
// ----------------------------------------------------------------------------
// Peer table checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptl_checker
  import ptl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      done,
  input out_item_t result
);

  // no result directly after reset
  a_reset_quiet : assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result strobe right after reset");

  // results are never back to back
  a_done_gap : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe on two consecutive cycles");

  // new_peer flags exactly the inserted status
  a_new_peer : assert property (@(posedge clk) disable iff (rst)
      done |-> (result.new_peer == (result.status == ST_NEW)))
    else $error("new_peer disagrees with status");

  // any_online tracks online_count
  a_any_online : assert property (@(posedge clk) disable iff (rst)
      done |-> (result.any_online == (result.online_count != '0)))
    else $error("any_online disagrees with online_count");

  // status is one of the defined codes
  a_status_code : assert property (@(posedge clk) disable iff (rst)
      done |-> (result.status == ST_NEW || result.status == ST_KNOWN ||
                result.status == ST_BCAST || result.status == ST_FULL ||
                result.status == ST_DONE))
    else $error("undefined status code");

endmodule

bind peer_table_with_liveness_aging ptl_checker u_ptl_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);

FILE: bench/peer_table_with_liveness_aging_tb.sv
// ----------------------------------------------------------------------------
// Peer table with liveness aging testbench
// Drives register, activity, sweep and clear commands through the start/busy
// port with random sender gaps, and predicts every result with its own model
// of the table (insertion order, last-seen time, online flags, wrapping
// timeout). Each done pulse is checked field by field against the oldest
// predicted result. The run covers several timeout and min_devices settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_table_with_liveness_aging_tb;
  import ptl_pkg::*;

  localparam int MAX_PEERS      = 16;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 272;
  localparam int POOL_SIZE      = 20;
  localparam int DRAIN_CYCLES   = 3 * (MAX_PEERS + 6);
  localparam int WATCHDOG_LIMIT = 2000;

  // --------------------------------------------------------------------------
  // Table model: tracks the peer table and queues the predicted results
  // --------------------------------------------------------------------------
  class peer_table_model;
    bit [MAC_W-1:0]  address [MAX_PEERS];
    bit [TIME_W-1:0] stamp_ms [MAX_PEERS];
    bit              online [MAX_PEERS];
    int unsigned     stored;
    bit [TIME_W-1:0] timeout_ms;
    bit [CNT_W-1:0]  min_devices;
    out_item_t       expected_results [$];
    int unsigned     errors;

    function new();
      stored      = 0;
      timeout_ms  = 5000;
      min_devices = 2;
      errors      = 0;
      foreach (online[i]) online[i] = 1'b0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
      if (idx == REG_TIMEOUT) timeout_ms = val;
      else if (idx == REG_MIN_DEV) min_devices = val[CNT_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // apply one accepted command and queue the result it must produce
    function void accept_command(in_item_t c);
      out_item_t   r;
      int          hit;
      int unsigned n_online;
      int unsigned n_seen;
      int unsigned devices;
      bit [TIME_W-1:0] age;
      r        = '0;
      r.status = ST_DONE;
      hit      = -1;
      n_online = 0;
      n_seen   = 0;
      if (c.action == ACT_REGISTER || c.action == ACT_ACTIVITY) begin
        if (c.mac == BCAST_MAC) begin
          r.status = ST_BCAST;
        end else begin
          for (int i = 0; i < stored; i++)
            if (hit < 0 && address[i] == c.mac) hit = i;
          if (hit >= 0) begin
            r.status = ST_KNOWN;
            if (c.action == ACT_ACTIVITY) begin
              stamp_ms[hit] = c.now_ms;
              online[hit]   = 1'b1;
            end
          end else if (stored >= MAX_PEERS) begin
            r.status = ST_FULL;
          end else begin
            address[stored]  = c.mac;
            stamp_ms[stored] = c.now_ms;
            online[stored]   = 1'b1;
            stored++;
            r.status   = ST_NEW;
            r.new_peer = 1'b1;
          end
        end
      end else if (c.action == ACT_SWEEP) begin
        // wrapping age; a zero stamp is never aged out
        for (int i = 0; i < stored; i++) begin
          age = c.now_ms - stamp_ms[i];
          if (online[i] && stamp_ms[i] != 0 && age > timeout_ms) online[i] = 1'b0;
        end
      end else begin
        for (int i = 0; i < MAX_PEERS; i++) begin
          address[i]  = '0;
          stamp_ms[i] = '0;
          online[i]   = 1'b0;
        end
        stored = 0;
      end
      for (int i = 0; i < stored; i++) begin
        if (online[i]) n_online++;
        if (stamp_ms[i] != 0) n_seen++;
      end
      devices        = stored + 1;
      r.online_count = n_online[CNT_W-1:0];
      r.seen_count   = n_seen[CNT_W-1:0];
      r.device_count = devices[CNT_W-1:0];
      r.ready_res    = (devices >= min_devices);
      r.any_online   = (n_online > 0);
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // compare one result transfer with the oldest prediction
    function void compare_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("new_peer", want.new_peer, got.new_peer);
        check_field("online_count", want.online_count, got.online_count);
        check_field("seen_count", want.seen_count, got.seen_count);
        check_field("device_count", want.device_count, got.device_count);
        check_field("ready_res", want.ready_res, got.ready_res);
        check_field("any_online", want.any_online, got.any_online);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             cmd = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;
  logic                 done;
  out_item_t            result;

  peer_table_with_liveness_aging #(.MAX_PEERS(MAX_PEERS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  peer_table_model model;
  int unsigned     quiet_cycles = 0;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) model.accept_command(cmd);
      if (done) model.compare_result(result);
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  bit [MAC_W-1:0]  mac_pool [POOL_SIZE];
  bit [TIME_W-1:0] wall_ms;

  // hold the command until it transfers, then optionally idle
  task automatic send_command(input in_item_t c, input int gap);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic directed(input logic [1:0] act, input logic [MAC_W-1:0] m,
                          input logic [TIME_W-1:0] t);
    in_item_t c;
    c.action = act;
    c.mac    = m;
    c.now_ms = t;
    send_command(c, 0);
  endtask

  // one write cycle followed by one idle cycle on the write port
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    model.set_register(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic bit [MAC_W-1:0] random_mac();
    bit [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[MAC_W-1:0];
  endfunction

  // mostly a small pool so hits and a full table are common
  function automatic in_item_t random_command();
    in_item_t c;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 40) c.action = ACT_ACTIVITY;
    else if (r < 72) c.action = ACT_REGISTER;
    else if (r < 98) c.action = ACT_SWEEP;
    else c.action = ACT_CLEAR;
    r = $urandom_range(0, 99);
    if (r < 3) c.mac = BCAST_MAC;
    else if (r < 5) c.mac = '0;
    else if (r < 15) c.mac = random_mac();
    else c.mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    r = $urandom_range(0, 99);
    if (r < 3) wall_ms = '0;
    else if (r < 6) wall_ms = $urandom;
    else if (r < 12) wall_ms += $urandom_range(0, 40000);
    else wall_ms += $urandom_range(0, 2500);
    c.now_ms = wall_ms;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    bit [TIME_W-1:0] timeouts [PHASES];
    bit [TIME_W-1:0] min_devs [PHASES];
    int              gap;
    bit              last_phase;

    model = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: time zero stamp, broadcast, known MAC, sweep edges, full table
    write_reg(REG_TIMEOUT, 32'd5000);
    write_reg(REG_MIN_DEV, 32'd2);
    directed(ACT_REGISTER, 48'h0, 32'd0);
    directed(ACT_REGISTER, BCAST_MAC, 32'd10);
    directed(ACT_ACTIVITY, BCAST_MAC, 32'd20);
    directed(ACT_REGISTER, 48'h0, 32'd50);
    directed(ACT_ACTIVITY, 48'h8000_0000_0001, 32'd100);
    directed(ACT_SWEEP, 48'h0, 32'd6101);
    directed(ACT_ACTIVITY, 48'h0, 32'd7000);
    directed(ACT_ACTIVITY, 48'h8000_0000_0001, 32'd7100);
    directed(ACT_SWEEP, 48'h0, 32'd12100);
    directed(ACT_ACTIVITY, 48'h8000_0000_0001, 32'hFFFF_FF00);
    directed(ACT_SWEEP, BCAST_MAC, 32'h0000_1000);
    directed(ACT_REGISTER, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFF);
    directed(ACT_REGISTER, 48'h5555_5555_5555, 32'd1);
    directed(ACT_REGISTER, 48'hAAAA_AAAA_AAAA, 32'h8000_0000);
    for (int i = 0; i < MAX_PEERS - 5; i++)
      directed(ACT_REGISTER, random_mac(), $urandom);
    directed(ACT_ACTIVITY, 48'h1234_5678_9ABC, 32'd400);
    directed(ACT_CLEAR, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // register settings per phase, extremes included
    timeouts = '{32'd5000, 32'd0, 32'hFFFF_FFFF, 32'd1500, 32'd0, 32'd3000};
    min_devs = '{32'd2, 32'd1, 32'd17, 32'd9, 32'd0, 32'd17};
    timeouts[4] = $urandom_range(0, 20000);
    min_devs[4] = $urandom_range(1, 17);

    for (int p = 0; p < PHASES; p++) begin
      last_phase = (p == PHASES - 1);
      write_reg(REG_TIMEOUT, timeouts[p]);
      write_reg(REG_MIN_DEV, min_devs[p]);
      foreach (mac_pool[i]) mac_pool[i] = random_mac();
      wall_ms = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        gap = 0;
        // sender gaps come in stretches, with quiet stretches between
        if (!last_phase && ((n / 40) % 2 == 0) && $urandom_range(0, 2) == 0)
          gap = $urandom_range(1, 6);
        send_command(random_command(), gap);
      end
      drain();
    end

    if (model.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ptl_pkg.sv
hdl/ptl_front.sv
hdl/ptl_back.sv
hdl/peer_table_with_liveness_aging.sv
hdl/ptl_checker.sv
bench/peer_table_with_liveness_aging_tb.sv
